### sv/isid_pkg.sv
// Shared types and constants for the indexed sequence block.
package isid_pkg;

	localparam int CAPACITY   = 64;
	localparam int ITEM_WIDTH = 32;

	// Fixed widths of the request and response fields.
	localparam int ACTION_W = 3;
	localparam int POS_W    = 7;
	localparam int VALUE_W  = 32;
	localparam int LEN_W    = 7;
	localparam int STATUS_W = 2;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W + 1 : POS_W + 1;

	typedef logic [ITEM_WIDTH-1:0] item_t;
	typedef logic [CNT_W-1:0]      count_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_INIT   = 3'd0,
		ACT_GET    = 3'd1,
		ACT_SET    = 3'd2,
		ACT_INSERT = 3'd3,
		ACT_DELETE = 3'd4
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_BOUND = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// What every cell of the row does in the cycle of an accepted request.
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_CLEAR,
		OP_WRITE,
		OP_INSERT,
		OP_DELETE
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		item_t    value;
	} cell_cmd_t;

	typedef struct packed {
		cell_op_t op;
		status_t  status;
		logic     rd_en;
		count_t   count;
	} dec_t;

endpackage

### sv/indexed_sequence_insert_delete.sv
// Top level of the indexed sequence: a row of item cells with insert and delete by position.
//
//   channel   direction  handshake            fields
//   request   in         in_valid / in_stall   action, position, item_value, new_length
//   response  out        out_valid / out_stall status, read_value, length
//
// Every request completes in the cycle it is accepted: the row of cells shifts all
// items up or down at once, so one request per cycle is sustained while in_stall is low,
// and the response appears in the output register in the cycle after acceptance.
// Reset clears every cell to zero and the item count to zero; no sweep is needed.
// While a response waits in the output register under out_stall, in_stall is raised
// and no further request is taken; the register is freed in the same edge it is read.
module indexed_sequence_insert_delete (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [isid_pkg::ACTION_W-1:0]     action,
	input  logic [isid_pkg::POS_W-1:0]        position,
	input  logic [isid_pkg::VALUE_W-1:0]      item_value,
	input  logic [isid_pkg::LEN_W-1:0]        new_length,

	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [isid_pkg::STATUS_W-1:0]     status,
	output logic [isid_pkg::VALUE_W-1:0]      read_value,
	output logic [isid_pkg::LEN_W-1:0]        length
);

	localparam int CAP = isid_pkg::CAPACITY;

	// Handshake state of the output register.
	logic in_acc;
	logic out_valid_q;

	// Number of items currently held; entries at and above it are always zero.
	isid_pkg::count_t count_q;

	// Decoded request.
	isid_pkg::dec_t    dec;
	isid_pkg::cell_cmd_t cmd;

	// Values held in the row, one per cell.
	isid_pkg::item_t item_w [CAP];
	isid_pkg::item_t rd_item;

	// Response register.
	isid_pkg::status_t              status_q;
	logic [isid_pkg::VALUE_W-1:0]   read_value_q;
	logic [isid_pkg::LEN_W-1:0]     length_q;

	assign in_stall = out_valid_q && out_stall;
	assign in_acc   = in_valid && !in_stall;

	isid_decode u_decode (
		.action     (action),
		.position   (position),
		.new_length (new_length),
		.count      (count_q),
		.dec        (dec)
	);

	assign cmd.op    = dec.op;
	assign cmd.value = isid_pkg::ITEM_WIDTH'(item_value);

	// The row of cells. Each cell learns from the broadcast position whether it sits
	// on it or past it, and takes its new value from itself, a neighbor or the request.
	for (genvar i = 0; i < CAP; i++) begin : g_cell
		logic            at_pos;
		logic            past_pos;
		isid_pkg::item_t below;
		isid_pkg::item_t above;

		assign at_pos   = isid_pkg::CMP_W'(position) == isid_pkg::CMP_W'(i);
		assign past_pos = isid_pkg::CMP_W'(i) > isid_pkg::CMP_W'(position);

		if (i == 0) begin : g_first
			assign below = '0;
		end else begin : g_inner_lo
			assign below = item_w[i-1];
		end

		// The top cell pulls in zero on delete, which clears the vacated slot.
		if (i == CAP - 1) begin : g_last
			assign above = '0;
		end else begin : g_inner_hi
			assign above = item_w[i+1];
		end

		isid_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (in_acc),
			.cmd      (cmd),
			.at_pos   (at_pos),
			.past_pos (past_pos),
			.below    (below),
			.above    (above),
			.item     (item_w[i])
		);
	end

	// Read port of the row for get; the decode only enables it for an in-range position.
	assign rd_item = item_w[isid_pkg::IDX_W'(position)];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				count_q <= dec.count;
			end
			if (in_acc) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			status_q     <= dec.status;
			read_value_q <= dec.rd_en ? isid_pkg::VALUE_W'(rd_item) : '0;
			length_q     <= isid_pkg::LEN_W'(dec.count);
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign read_value = read_value_q;
	assign length     = length_q;

	// A successful insert grows the list by exactly one item.
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && dec.op == isid_pkg::OP_INSERT |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not grow the item count by one");

	// A rejected request leaves the item count untouched.
	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && dec.status != isid_pkg::ST_OK |=> $stable(count_q))
		else $error("rejected request changed the item count");

	// Slots above the length stay clear, so the top cell is zero unless the row is full.
	a_top_clear: assert property (@(posedge clk) disable iff (!arst_n)
		isid_pkg::CMP_W'(count_q) < isid_pkg::CMP_W'(CAP) |-> item_w[CAP-1] == '0)
		else $error("top cell holds data while the row is not full");

	// The reported length always matches the count register after a response is loaded.
	a_length_match: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> length_q == isid_pkg::LEN_W'(count_q))
		else $error("response length differs from the item count");

endmodule

### sv/isid_cell.sv
// One storage cell of the item row, exchanging its value with both neighbors.
module isid_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  isid_pkg::cell_cmd_t cmd,
	input  logic                at_pos,
	input  logic                past_pos,
	input  isid_pkg::item_t     below,
	input  isid_pkg::item_t     above,
	output isid_pkg::item_t     item
);

	isid_pkg::item_t item_q;
	isid_pkg::item_t item_d;

	always_comb begin
		item_d = item_q;
		case (cmd.op)
			isid_pkg::OP_CLEAR: begin
				item_d = '0;
			end
			isid_pkg::OP_WRITE: begin
				if (at_pos) item_d = cmd.value;
			end
			isid_pkg::OP_INSERT: begin
				// Cells above the position take the value of the cell below them.
				if (past_pos) item_d = below;
				else if (at_pos) item_d = cmd.value;
			end
			isid_pkg::OP_DELETE: begin
				if (at_pos || past_pos) item_d = above;
			end
			default: begin
				item_d = item_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_q <= '0;
		end else if (en) begin
			item_q <= item_d;
		end
	end

	assign item = item_q;

endmodule

### sv/isid_decode.sv
// Request decode: range checks, status, row command and the new item count.
module isid_decode (
	input  logic [isid_pkg::ACTION_W-1:0] action,
	input  logic [isid_pkg::POS_W-1:0]    position,
	input  logic [isid_pkg::LEN_W-1:0]    new_length,
	input  isid_pkg::count_t              count,
	output isid_pkg::dec_t                dec
);

	logic [isid_pkg::CMP_W-1:0] pos_c;
	logic [isid_pkg::CMP_W-1:0] cnt_c;
	logic [isid_pkg::CMP_W-1:0] nlen_c;
	logic [isid_pkg::CMP_W-1:0] cap_c;

	assign pos_c  = isid_pkg::CMP_W'(position);
	assign cnt_c  = isid_pkg::CMP_W'(count);
	assign nlen_c = isid_pkg::CMP_W'(new_length);
	assign cap_c  = isid_pkg::CMP_W'(isid_pkg::CAPACITY);

	always_comb begin
		dec.op     = isid_pkg::OP_HOLD;
		dec.status = isid_pkg::ST_OK;
		dec.rd_en  = 1'b0;
		dec.count  = count;
		case (action)
			isid_pkg::ACT_INIT: begin
				if (nlen_c > cap_c) begin
					dec.status = isid_pkg::ST_FULL;
				end else begin
					dec.op    = isid_pkg::OP_CLEAR;
					dec.count = isid_pkg::CNT_W'(new_length);
				end
			end
			isid_pkg::ACT_GET: begin
				if (pos_c >= cnt_c) dec.status = isid_pkg::ST_BOUND;
				else dec.rd_en = 1'b1;
			end
			isid_pkg::ACT_SET: begin
				if (pos_c >= cnt_c) dec.status = isid_pkg::ST_BOUND;
				else dec.op = isid_pkg::OP_WRITE;
			end
			isid_pkg::ACT_INSERT: begin
				if (pos_c > cnt_c) begin
					dec.status = isid_pkg::ST_BOUND;
				end else if (cnt_c >= cap_c) begin
					dec.status = isid_pkg::ST_FULL;
				end else begin
					dec.op    = isid_pkg::OP_INSERT;
					dec.count = isid_pkg::CNT_W'(count + 1'b1);
				end
			end
			isid_pkg::ACT_DELETE: begin
				// An empty list also fails here, so no underflow code exists.
				if (pos_c >= cnt_c) begin
					dec.status = isid_pkg::ST_BOUND;
				end else begin
					dec.op    = isid_pkg::OP_DELETE;
					dec.count = isid_pkg::CNT_W'(count - 1'b1);
				end
			end
			default: begin
				dec.op = isid_pkg::OP_HOLD;
			end
		endcase
	end

endmodule
